// File: rtl/bmap_pkg.sv
// Shared types and constants of the bank mapper with scanline interrupt.
`default_nettype none
package bmap_pkg;

   localparam int OP_W      = 3;
   localparam int ADDR_W    = 16;
   localparam int DATA_W    = 8;
   localparam int MAP_W     = 22;
   localparam int COUNT_W   = 8;
   localparam int PRG_PAGE_W = 9;

   // Reset value of the PRG bank count register.
   localparam logic [COUNT_W-1:0] BANK_COUNT_RESET = 8'd2;

   typedef enum logic [OP_W-1:0] {
      OP_CPU_READ  = 3'd0,
      OP_CPU_WRITE = 3'd1,
      OP_PPU_READ  = 3'd2,
      OP_TICK      = 3'd3,
      OP_IRQ_ACK   = 3'd4
   } opcode_type;

   // CPU address bits [15:13].
   typedef enum logic [2:0] {
      REGION_RAM        = 3'd3,
      REGION_BANK       = 3'd4,
      REGION_MIRROR     = 3'd5,
      REGION_IRQ_LATCH  = 3'd6,
      REGION_IRQ_ENABLE = 3'd7
   } region_type;

   typedef struct packed {
      logic [MAP_W-1:0]  mapped_address;
      logic              rom_hit;
      logic [DATA_W-1:0] ram_read_data;
      logic              ram_hit;
      logic              mirror_horizontal;
      logic              irq_line;
   } rsp_payload_type;

endpackage
`default_nettype wire

// File: rtl/bmap_req_if.sv
// Request channel: one bus event per transaction.
`default_nettype none
interface bmap_req_if;
   import bmap_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output opcode, output address, output write_data,
                   input ready);
   modport sink   (input valid, input opcode, input address, input write_data,
                   output ready);
endinterface
`default_nettype wire

// File: rtl/bmap_rsp_if.sv
// Response channel: translated address, RAM data, mirroring and IRQ state.
`default_nettype none
interface bmap_rsp_if;
   import bmap_pkg::*;

   logic              valid;
   logic              ready;
   logic [MAP_W-1:0]  mapped_address;
   logic              rom_hit;
   logic [DATA_W-1:0] ram_read_data;
   logic              ram_hit;
   logic              mirror_horizontal;
   logic              irq_line;

   modport source (output valid, output mapped_address, output rom_hit,
                   output ram_read_data, output ram_hit, output mirror_horizontal,
                   output irq_line, input ready);
   modport sink   (input valid, input mapped_address, input rom_hit,
                   input ram_read_data, input ram_hit, input mirror_horizontal,
                   input irq_line, output ready);
endinterface
`default_nettype wire

// File: rtl/bank_mapper_with_scanline_irq.sv
// Bank mapper with scanline IRQ: registers in flops, PRG RAM in a synchronous memory.
// Path: a request passes the RAM read stage register, then a 3-entry output queue.
// Throughput: one transaction per cycle while responses are taken; single-port RAM with
// registered read data. The queue keeps the input open while a response waits, until
// queue and read stage hold three responses. Reset clears all mapper registers to their
// power-up values; PRG RAM contents are not cleared.
`default_nettype none
module bank_mapper_with_scanline_irq #(
   parameter int PRG_RAM_BYTES = 8192
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [bmap_pkg::COUNT_W-1:0]  csr_write_data,
   bmap_req_if.sink                           req_if,
   bmap_rsp_if.source                         rsp_if
);
   import bmap_pkg::*;

   localparam int RAM_AW    = $clog2(PRG_RAM_BYTES);
   localparam int RED_STEPS = (PRG_RAM_BYTES >= 8192) ? 0 :
                              $clog2((8192 + PRG_RAM_BYTES - 1) / PRG_RAM_BYTES);
   localparam int Q_DEPTH   = 3;

   // Mapper registers
   logic [COUNT_W-1:0] rom_bank_count_ff;
   logic [2:0]         bank_select_ff,  bank_select_in;
   logic               prg_swap_ff,     prg_swap_in;
   logic               chr_invert_ff,   chr_invert_in;
   logic [7:0]         bank_ff [8];
   logic [7:0]         bank_in [8];
   logic               mirror_ff,       mirror_in;
   logic [7:0]         irq_count_ff,    irq_count_in;
   logic [7:0]         irq_latch_ff,    irq_latch_in;
   logic               irq_enabled_ff,  irq_enabled_in;
   logic               irq_pending_ff,  irq_pending_in;

   // PRG RAM
   logic [DATA_W-1:0]  prg_ram [PRG_RAM_BYTES];
   logic [DATA_W-1:0]  ram_rdata_ff;
   logic [14:0]        ram_off;
   logic [RAM_AW-1:0]  ram_idx;
   logic               ram_we;
   logic               ram_re;

   // Read stage
   logic               s1_valid_ff;
   rsp_payload_type    s1_data_ff, s1_data_in;
   logic               s1_ram_sel_ff, s1_ram_sel_in;

   // Output queue
   rsp_payload_type    q_ff [Q_DEPTH];
   rsp_payload_type    push_data;
   logic [1:0]         wr_ptr_ff, rd_ptr_ff, q_count_ff;
   logic               push, pop;

   logic               accept;
   logic [2:0]         region;
   logic               ram_region;
   logic               odd;
   logic [PRG_PAGE_W-1:0] last_bank, second_bank, prg_window_bank;
   logic [2:0]         chr_slot;
   logic [7:0]         chr_window_bank;
   logic [7:0]         tick_count;

   function automatic logic [1:0] ptr_next(input logic [1:0] p);
      return (p == 2'(Q_DEPTH - 1)) ? 2'd0 : p + 2'd1;
   endfunction

   assign req_if.ready = ({1'b0, q_count_ff} + {2'b00, s1_valid_ff}) <= 3'd2;
   assign accept       = req_if.valid && req_if.ready;

   assign region     = req_if.address[15:13];
   assign ram_region = (region == REGION_RAM);
   assign odd        = req_if.address[0];

   // RAM index: address offset reduced modulo the RAM size by compare-subtract steps
   always_comb begin
      ram_off = {2'b00, req_if.address[12:0]};
      for (int i = RED_STEPS - 1; i >= 0; i--) begin
         if (ram_off >= 15'(PRG_RAM_BYTES << i)) begin
            ram_off = ram_off - 15'(PRG_RAM_BYTES << i);
         end
      end
   end
   assign ram_idx = ram_off[RAM_AW-1:0];

   // PRG window bank
   assign last_bank   = {rom_bank_count_ff, 1'b0} - 9'd1;
   assign second_bank = {rom_bank_count_ff, 1'b0} - 9'd2;

   always_comb begin
      unique case (req_if.address[14:13])
         2'd0: prg_window_bank = prg_swap_ff ? second_bank : {3'b000, bank_ff[6][5:0]};
         2'd1: prg_window_bank = {3'b000, bank_ff[7][5:0]};
         2'd2: prg_window_bank = prg_swap_ff ? {3'b000, bank_ff[6][5:0]} : second_bank;
         2'd3: prg_window_bank = last_bank;
      endcase
   end

   // CHR window bank; inversion swaps the two 4 KB halves
   assign chr_slot = req_if.address[12:10] ^ {chr_invert_ff, 2'b00};
   always_comb begin
      if (!chr_slot[2]) begin
         chr_window_bank = {bank_ff[{2'b00, chr_slot[1]}][7:1], chr_slot[0]};
      end else begin
         chr_window_bank = bank_ff[chr_slot - 3'd2];
      end
   end

   assign tick_count = (irq_count_ff == 8'd0) ? irq_latch_ff : irq_count_ff - 8'd1;

   // Next register state and the response fields of the accepted transaction
   always_comb begin
      bank_select_in = bank_select_ff;
      prg_swap_in    = prg_swap_ff;
      chr_invert_in  = chr_invert_ff;
      bank_in        = bank_ff;
      mirror_in      = mirror_ff;
      irq_count_in   = irq_count_ff;
      irq_latch_in   = irq_latch_ff;
      irq_enabled_in = irq_enabled_ff;
      irq_pending_in = irq_pending_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      s1_ram_sel_in  = 1'b0;
      s1_data_in     = '0;
      if (accept) begin
         case (req_if.opcode)
            OP_CPU_READ: begin
               if (ram_region) begin
                  ram_re             = 1'b1;
                  s1_ram_sel_in      = 1'b1;
                  s1_data_in.ram_hit = 1'b1;
               end else if (req_if.address[15]) begin
                  s1_data_in.rom_hit        = 1'b1;
                  s1_data_in.mapped_address = {prg_window_bank, req_if.address[12:0]};
               end
            end
            OP_CPU_WRITE: begin
               case (region)
                  REGION_RAM: begin
                     ram_we             = 1'b1;
                     s1_data_in.ram_hit = 1'b1;
                  end
                  REGION_BANK: begin
                     if (!odd) begin
                        bank_select_in = req_if.write_data[2:0];
                        prg_swap_in    = req_if.write_data[6];
                        chr_invert_in  = req_if.write_data[7];
                     end else begin
                        bank_in[bank_select_ff] = req_if.write_data;
                     end
                  end
                  REGION_MIRROR: begin
                     if (!odd) begin
                        mirror_in = req_if.write_data[0];
                     end
                  end
                  REGION_IRQ_LATCH: begin
                     if (!odd) begin
                        irq_latch_in = req_if.write_data;
                     end else begin
                        irq_count_in = 8'd0;
                     end
                  end
                  REGION_IRQ_ENABLE: begin
                     if (!odd) begin
                        irq_enabled_in = 1'b0;
                        irq_pending_in = 1'b0;
                     end else begin
                        irq_enabled_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_PPU_READ: begin
               if (req_if.address[15:13] == 3'd0) begin
                  s1_data_in.rom_hit        = 1'b1;
                  s1_data_in.mapped_address = {4'b0000, chr_window_bank,
                                               req_if.address[9:0]};
               end
            end
            OP_TICK: begin
               irq_count_in = tick_count;
               if (tick_count == 8'd0 && irq_enabled_ff) begin
                  irq_pending_in = 1'b1;
               end
            end
            OP_IRQ_ACK: begin
               irq_pending_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      s1_data_in.mirror_horizontal = mirror_in;
      s1_data_in.irq_line          = irq_pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_bank_count_ff <= BANK_COUNT_RESET;
         bank_select_ff    <= 3'd0;
         prg_swap_ff       <= 1'b0;
         chr_invert_ff     <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            bank_ff[i] <= (i == 7) ? 8'd1 : 8'd0;
         end
         mirror_ff         <= 1'b1;
         irq_count_ff      <= 8'd0;
         irq_latch_ff      <= 8'd0;
         irq_enabled_ff    <= 1'b0;
         irq_pending_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            rom_bank_count_ff <= csr_write_data;
         end
         bank_select_ff <= bank_select_in;
         prg_swap_ff    <= prg_swap_in;
         chr_invert_ff  <= chr_invert_in;
         bank_ff        <= bank_in;
         mirror_ff      <= mirror_in;
         irq_count_ff   <= irq_count_in;
         irq_latch_ff   <= irq_latch_in;
         irq_enabled_ff <= irq_enabled_in;
         irq_pending_ff <= irq_pending_in;
      end
   end

   // Single-port PRG RAM with registered read data
   always_ff @(posedge clock) begin
      if (ram_we) begin
         prg_ram[ram_idx] <= req_if.write_data;
      end
      if (ram_re) begin
         ram_rdata_ff <= prg_ram[ram_idx];
      end
   end

   // Read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff    <= s1_data_in;
         s1_ram_sel_ff <= s1_ram_sel_in;
      end
   end

   // Output queue; ready accounting guarantees room for the read stage
   assign push = s1_valid_ff;
   assign pop  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      push_data = s1_data_ff;
      if (s1_ram_sel_ff) begin
         push_data.ram_read_data = ram_rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= 2'd0;
         rd_ptr_ff  <= 2'd0;
         q_count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         q_count_ff <= q_count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_if.valid             = (q_count_ff != 2'd0);
   assign rsp_if.mapped_address    = q_ff[rd_ptr_ff].mapped_address;
   assign rsp_if.rom_hit           = q_ff[rd_ptr_ff].rom_hit;
   assign rsp_if.ram_read_data     = q_ff[rd_ptr_ff].ram_read_data;
   assign rsp_if.ram_hit           = q_ff[rd_ptr_ff].ram_hit;
   assign rsp_if.mirror_horizontal = q_ff[rd_ptr_ff].mirror_horizontal;
   assign rsp_if.irq_line          = q_ff[rd_ptr_ff].irq_line;

   // Queue plus read stage never hold more than the queue depth
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_count_ff} + {2'b00, s1_valid_ff}) <= 3'(Q_DEPTH))
      else $error("output queue overflow");

   // Every accepted transaction reaches the read stage
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transaction lost before read stage");

   // Pending IRQ clears only on reset, acknowledge or an IRQ-disable write
   assert property (@(posedge clock) disable iff (reset)
      $fell(irq_pending_ff) |->
         ($past(reset) ||
          ($past(accept) && ($past(req_if.opcode) == OP_IRQ_ACK)) ||
          ($past(accept) && ($past(req_if.opcode) == OP_CPU_WRITE) &&
           ($past(req_if.address[15:13]) == REGION_IRQ_ENABLE) &&
           !$past(req_if.address[0]))))
      else $error("irq pending cleared without cause");

endmodule
`default_nettype wire

// File: bench/bmap_scoreboard.sv
`timescale 1ns / 1ps
// Scoreboard for the bank mapper: predicts each response from observed requests and checks it.
module bmap_scoreboard #(
   parameter int PRG_RAM_BYTES = 8192
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [bmap_pkg::COUNT_W-1:0] csr_write_data,
   bmap_req_if                               req_mon,
   bmap_rsp_if                               rsp_mon,
   output int                                mismatch_count,
   output int                                outstanding
);
   import bmap_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // mapper state as the bus events have left it
   logic [COUNT_W-1:0] bank_count;
   logic [2:0]         select_index;
   logic               prg_swap;
   logic               chr_invert;
   logic [7:0]         bank_reg [8];
   logic               mirror_h;
   logic [7:0]         scan_count;
   logic [7:0]         scan_latch;
   logic               irq_armed;
   logic               irq_flag;
   logic [DATA_W-1:0]  ram_image [PRG_RAM_BYTES];

   rsp_payload_type expected_rsp [$];
   int errors;

   function automatic int ram_slot(input logic [ADDR_W-1:0] a);
      return int'(a[12:0]) % PRG_RAM_BYTES;
   endfunction

   function automatic logic [MAP_W-1:0] prg_rom_address(input logic [ADDR_W-1:0] a);
      logic [PRG_PAGE_W-1:0] last_bank;
      logic [PRG_PAGE_W-1:0] next_to_last;
      logic [PRG_PAGE_W-1:0] swap_bank;
      logic [PRG_PAGE_W-1:0] bank;
      // bank numbers are 9 bits wide and wrap, so a count of zero gives 511 / 510
      last_bank    = {bank_count, 1'b0} - 9'd1;
      next_to_last = {bank_count, 1'b0} - 9'd2;
      swap_bank    = {3'b000, bank_reg[6][5:0]};
      case (a[14:13])
         2'd0:    bank = prg_swap ? next_to_last : swap_bank;
         2'd1:    bank = {3'b000, bank_reg[7][5:0]};
         2'd2:    bank = prg_swap ? swap_bank : next_to_last;
         default: bank = last_bank;
      endcase
      return {bank, a[12:0]};
   endfunction

   function automatic logic [MAP_W-1:0] chr_rom_address(input logic [ADDR_W-1:0] a);
      logic [2:0] slot;
      logic [7:0] bank;
      slot = a[12:10] ^ {chr_invert, 2'b00};
      if (!slot[2]) begin
         bank = {bank_reg[{2'b00, slot[1]}][7:1], slot[0]};
      end else begin
         bank = bank_reg[slot - 3'd2];
      end
      return {4'b0000, bank, a[9:0]};
   endfunction

   function automatic void register_write(input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] d);
      case (a[15:13])
         REGION_RAM: ram_image[ram_slot(a)] = d;
         REGION_BANK: begin
            if (!a[0]) begin
               select_index = d[2:0];
               prg_swap     = d[6];
               chr_invert   = d[7];
            end else begin
               bank_reg[select_index] = d;
            end
         end
         REGION_MIRROR: begin
            // odd addresses are the RAM protect register, which has no effect here
            if (!a[0]) mirror_h = d[0];
         end
         REGION_IRQ_LATCH: begin
            if (!a[0]) scan_latch = d;
            else scan_count = '0;
         end
         REGION_IRQ_ENABLE: begin
            if (!a[0]) begin
               irq_armed = 1'b0;
               irq_flag  = 1'b0;
            end else begin
               irq_armed = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type mapper_response(input logic [OP_W-1:0]   op,
                                                       input logic [ADDR_W-1:0] a,
                                                       input logic [DATA_W-1:0] d);
      rsp_payload_type r;
      logic in_ram;
      r = '0;
      in_ram = (a[15:13] == REGION_RAM);
      case (op)
         OP_CPU_READ: begin
            if (in_ram) begin
               r.ram_hit = 1'b1;
               r.ram_read_data = ram_image[ram_slot(a)];
            end else if (a[15]) begin
               r.rom_hit = 1'b1;
               r.mapped_address = prg_rom_address(a);
            end
         end
         OP_CPU_WRITE: begin
            r.ram_hit = in_ram;
            register_write(a, d);
         end
         OP_PPU_READ: begin
            if (a < 16'h2000) begin
               r.rom_hit = 1'b1;
               r.mapped_address = chr_rom_address(a);
            end
         end
         OP_TICK: begin
            if (scan_count == 8'd0) scan_count = scan_latch;
            else scan_count = scan_count - 8'd1;
            if (scan_count == 8'd0 && irq_armed) irq_flag = 1'b1;
         end
         OP_IRQ_ACK: irq_flag = 1'b0;
         default: ;
      endcase
      r.mirror_horizontal = mirror_h;
      r.irq_line = irq_flag;
      return r;
   endfunction

   function automatic string describe(input rsp_payload_type r);
      return $sformatf("addr=%06h rom=%b data=%02h ram=%b mirror=%b irq=%b",
                       r.mapped_address, r.rom_hit, r.ram_read_data, r.ram_hit,
                       r.mirror_horizontal, r.irq_line);
   endfunction

   always @(posedge clock) begin : observe
      rsp_payload_type want;
      rsp_payload_type got;
      if (reset) begin
         bank_count   = BANK_COUNT_RESET;
         select_index = '0;
         prg_swap     = 1'b0;
         chr_invert   = 1'b0;
         for (int i = 0; i < 8; i++) bank_reg[i] = '0;
         bank_reg[7]  = 8'd1;
         mirror_h     = 1'b1;
         scan_count   = '0;
         scan_latch   = '0;
         irq_armed    = 1'b0;
         irq_flag     = 1'b0;
         errors       = 0;
         expected_rsp.delete();
      end else begin
         if (csr_write_enable) bank_count = csr_write_data;
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.mapped_address, rsp_mon.rom_hit, rsp_mon.ram_read_data,
                   rsp_mon.ram_hit, rsp_mon.mirror_horizontal, rsp_mon.irq_line};
            if (expected_rsp.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT)
                  $display("%0t: response with nothing outstanding: %s", $realtime,
                           describe(got));
            end else begin
               want = expected_rsp.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= REPORT_LIMIT)
                     $display("%0t: response mismatch\n  expected %s\n  actual   %s",
                              $realtime, describe(want), describe(got));
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp.push_back(mapper_response(req_mon.opcode, req_mon.address,
                                                   req_mon.write_data));
      end
      mismatch_count <= errors;
      outstanding    <= expected_rsp.size();
   end

endmodule

// File: bench/tb_bank_mapper_with_scanline_irq.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, bus event stimulus, response back-pressure and verdict.
module tb_bank_mapper_with_scanline_irq;
   import bmap_pkg::*;

   localparam int RAM_BYTES        = 8192;
   localparam int HALF_PERIOD_NS   = 6;
   localparam int RESET_CYCLES     = 5;
   localparam int PHASE_COUNT      = 5;
   localparam int ITEMS_PER_PHASE  = 245;
   localparam int MODE_STRETCH     = 40;
   localparam int QUIET_TAIL       = 150;
   localparam int LONG_HOLD_CYCLES = 40;
   localparam int RUN_LIMIT_NS     = 5_000_000;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;
   int                 mismatch_count;
   int                 outstanding;

   bit req_gaps;
   bit rsp_gaps;
   bit long_hold_request;
   int items_sent;
   bit ram_written [RAM_BYTES];
   int written_slots [$];

   bmap_req_if req_bus ();
   bmap_rsp_if rsp_bus ();

   always #(HALF_PERIOD_NS) clock = ~clock;

   bank_mapper_with_scanline_irq #(.PRG_RAM_BYTES(RAM_BYTES)) i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   bmap_scoreboard #(.PRG_RAM_BYTES(RAM_BYTES)) i_scoreboard (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   task automatic send_event(input logic [OP_W-1:0]   op,
                             input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
      int slot;
      slot = int'(addr[12:0]) % RAM_BYTES;
      // a PRG RAM byte is only read back after it has been written
      if (op == OP_CPU_READ && addr[15:13] == REGION_RAM && !ram_written[slot])
         op = OP_CPU_WRITE;
      if (op == OP_CPU_WRITE && addr[15:13] == REGION_RAM && !ram_written[slot]) begin
         ram_written[slot] = 1'b1;
         written_slots.push_back(slot);
      end
      if (req_gaps && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.address    <= addr;
      req_bus.write_data <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random_event();
      int pick;
      int slot;
      logic [ADDR_W-1:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: a = {1'b1, 15'($urandom)};
            6, 7: begin
               if (written_slots.size() != 0) begin
                  slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
                  a = {REGION_RAM, 13'(slot)};
               end else begin
                  a = {REGION_RAM, 13'($urandom)};
               end
            end
            8: a = 16'($urandom_range(0, 16'h5FFF));
            default: a = 16'($urandom);
         endcase
         send_event(OP_CPU_READ, a, 8'($urandom));
      end else if (pick < 40) begin
         a = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 16'h1FFF)) : 16'($urandom);
         send_event(OP_PPU_READ, a, 8'($urandom));
      end else if (pick < 58) begin
         // bank select followed by the bank data write
         send_event(OP_CPU_WRITE, {REGION_BANK, 12'($urandom), 1'b0}, 8'($urandom));
         send_event(OP_CPU_WRITE, {REGION_BANK, 12'($urandom), 1'b1}, 8'($urandom));
      end else if (pick < 68) begin
         send_event(OP_CPU_WRITE, {REGION_RAM, 13'($urandom)}, 8'($urandom));
      end else if (pick < 74) begin
         send_event(OP_CPU_WRITE, {REGION_MIRROR, 13'($urandom)}, 8'($urandom));
      end else if (pick < 80) begin
         // small reload values so the counter actually expires
         a = {($urandom_range(0, 1) != 0) ? REGION_IRQ_LATCH : REGION_IRQ_ENABLE,
              13'($urandom)};
         send_event(OP_CPU_WRITE, a,
                    ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom));
      end else if (pick < 93) begin
         repeat ($urandom_range(1, 6)) send_event(OP_TICK, 16'($urandom), 8'($urandom));
      end else if (pick < 96) begin
         send_event(OP_IRQ_ACK, 16'($urandom), 8'($urandom));
      end else if (pick < 98) begin
         send_event(OP_W'($urandom_range(OP_IRQ_ACK + 1, {OP_W{1'b1}})), 16'($urandom),
                    8'($urandom));
      end else begin
         send_event(OP_W'($urandom), 16'($urandom), 8'($urandom));
      end
   endtask

   task automatic wait_until_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_bank_count(input logic [COUNT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("bank_mapper_with_scanline_irq verification failed");
      $finish;
   end

   initial begin : response_sink
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold_request) begin
            // long back-pressure: the request side keeps offering and must stall
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_request = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int phase_end;
      int mode_change;
      bit hold_started;
      logic [COUNT_W-1:0] bank_counts [PHASE_COUNT];
      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_CPU_READ;
      req_bus.address    <= '0;
      req_bus.write_data <= '0;
      req_gaps     = 1'b0;
      rsp_gaps     = 1'b0;
      hold_started = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, bank count at its reset value
      send_event(OP_CPU_READ, 16'h8000, 8'h00);
      send_event(OP_CPU_READ, 16'hFFFF, 8'hFF);
      send_event(OP_CPU_WRITE, 16'h6000, 8'hFF);
      send_event(OP_CPU_WRITE, 16'h7FFF, 8'h00);
      send_event(OP_CPU_READ, 16'h6000, 8'h00);
      send_event(OP_CPU_READ, 16'h0000, 8'h00);
      send_event(OP_PPU_READ, 16'h2000, 8'h00);
      send_event(OP_CPU_WRITE, 16'h8000, 8'hC6);   // select R6, PRG swap, CHR invert
      send_event(OP_CPU_WRITE, 16'h8001, 8'hFF);
      send_event(OP_CPU_WRITE, 16'h9FFE, 8'hC1);   // select R1, modes kept
      send_event(OP_CPU_WRITE, 16'h9FFF, 8'hFF);   // odd 2 KB half of R1
      send_event(OP_PPU_READ, 16'h0000, 8'h00);
      send_event(OP_PPU_READ, 16'h1FFF, 8'h00);
      send_event(OP_CPU_READ, 16'hC123, 8'h00);
      send_event(OP_CPU_WRITE, 16'hA000, 8'h00);   // vertical mirroring
      send_event(OP_CPU_WRITE, 16'hBFFF, 8'hFF);   // RAM protect, ignored
      send_event(OP_CPU_WRITE, 16'hC000, 8'h02);
      send_event(OP_CPU_WRITE, 16'hE001, 8'h00);
      repeat (3) send_event(OP_TICK, 16'h0000, 8'h00);
      send_event(OP_IRQ_ACK, 16'h0000, 8'h00);
      send_event(OP_CPU_WRITE, 16'hDFFF, 8'h00);   // counter clear
      send_event(OP_CPU_WRITE, 16'hE000, 8'h00);
      send_event({OP_W{1'b1}}, 16'hFFFF, 8'hFF);

      bank_counts = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 254)),
                      8'($urandom_range(3, 254))};
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_until_drained();
         program_bank_count(bank_counts[p]);
         phase_end   = items_sent + ITEMS_PER_PHASE;
         mode_change = items_sent;
         while (items_sent < phase_end) begin
            if (p == PHASE_COUNT - 1 && phase_end - items_sent <= QUIET_TAIL) begin
               req_gaps = 1'b0;
               rsp_gaps = 1'b0;
            end else if (items_sent >= mode_change) begin
               req_gaps    = ($urandom_range(0, 2) != 0);
               rsp_gaps    = ($urandom_range(0, 2) != 0);
               mode_change = items_sent + MODE_STRETCH;
            end
            if (p == 0 && !hold_started && phase_end - items_sent <= ITEMS_PER_PHASE / 2) begin
               hold_started      = 1'b1;
               long_hold_request = 1'b1;
            end
            send_random_event();
         end
      end

      wait_until_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("bank_mapper_with_scanline_irq verification clean");
      end else begin
         $display("bank_mapper_with_scanline_irq verification failed");
      end
      $finish;
   end

endmodule
